// File: design/montgomery_modular_alu_macros.svh
// Assertion macros for the Montgomery modular unit
`ifndef MONTGOMERY_MODULAR_ALU_MACROS_SVH
`define MONTGOMERY_MODULAR_ALU_MACROS_SVH
`ifndef ASSERT_OFF
`define MMA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMA_ASSERT(label, clk, rst_n, prop, msg)
`define MMA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: design/mma_pkg.sv
`timescale 1ns / 1ps
package mma_pkg;
	localparam int unsigned REG_BITS = 64;
	typedef enum logic [2:0] {
		OP_MMUL = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_TOM  = 3'd3,
		OP_FROMM = 3'd4
	} op_t;
	typedef enum logic [1:0] {
		RA_MODULUS = 2'd0,
		RA_NEGINV  = 2'd1,
		RA_RSQ     = 2'd2
	} reg_addr_t;
endpackage

// File: design/mma_cell.sv
`timescale 1ns / 1ps
// One pipeline cell: a two-stage multiply of two words into a double word.
// The first stage registers four half-width partial products, the second their sum.
module mma_cell #(
	parameter int unsigned W = 64
) (
	input  logic           clk,
	input  logic [W-1:0]   x,
	input  logic [W-1:0]   y,
	output logic [2*W-1:0] prod_q
);
	localparam int unsigned H = (W + 1) / 2;
	localparam int unsigned L = W - H;

	logic [H-1:0]   xl, yl;
	logic [L-1:0]   xh, yh;
	logic [2*H-1:0] ll_s1;
	logic [H+L-1:0] lh_s1, hl_s1;
	logic [2*L-1:0] hh_s1;
	logic [2*W-1:0] ll_w, lh_w, hl_w, hh_w;

	assign xl = x[H-1:0];
	assign xh = x[W-1:H];
	assign yl = y[H-1:0];
	assign yh = y[W-1:H];

	// form the partial products
	always_ff @(posedge clk) begin
		ll_s1 <= {{H{1'b0}}, xl} * {{H{1'b0}}, yl};
		lh_s1 <= {{L{1'b0}}, xl} * {{H{1'b0}}, yh};
		hl_s1 <= {{H{1'b0}}, xh} * {{L{1'b0}}, yl};
		hh_s1 <= {{L{1'b0}}, xh} * {{L{1'b0}}, yh};
	end

	assign ll_w = {{(2*W-2*H){1'b0}}, ll_s1};
	assign lh_w = {{W{1'b0}}, lh_s1};
	assign hl_w = {{W{1'b0}}, hl_s1};
	assign hh_w = {{(2*H){1'b0}}, hh_s1};

	// sum the partial products and hold
	always_ff @(posedge clk) begin
		prod_q <= ll_w + (lh_w << H) + (hl_w << H) + (hh_w << (2 * H));
	end
endmodule

// File: design/montgomery_modular_alu.sv
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// item in   | opcode, operand_a, operand_b            | start high, busy low
// result    | result                                  | done strobe, one cycle
// config    | psel penable pwrite paddr pwdata prdata | APB, pready always high
// One word is taken every cycle.
// Three multiplier cells in a row (a*b, t*neg_inverse, m*p) each register
// half-width partial products, then their sum. A register stage then forms the
// reduce sum, the add and the difference; the last register takes the final subtract.
// busy is tied low: the pipeline never stalls and the receiver cannot stall.
// Reset clears the valid chain and loads the register reset values.
module montgomery_modular_alu #(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           opcode,
	input  logic [63:0]          operand_a,
	input  logic [63:0]          operand_b,
	output logic                 done,
	output logic [63:0]          result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);
	import mma_pkg::*;
	`include "montgomery_modular_alu_macros.svh"
	localparam int unsigned W = WORD_BITS;

	typedef struct packed {
		logic [2:0]   op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] p;
	} side_t;

	logic [63:0] modulus_q, neginv_q, rsq_q;
	logic [1:0]  ridx;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign ridx   = paddr[4:3];
	assign wr_en  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 64'd3;
			neginv_q  <= 64'h5555555555555555;
			rsq_q     <= 64'd1;
		end else if (wr_en && paddr[2:0] == 3'd0) begin
			unique case (ridx)
				RA_MODULUS: modulus_q <= pwdata;
				RA_NEGINV:  neginv_q  <= pwdata;
				RA_RSQ:     rsq_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) begin
			unique case (ridx)
				RA_MODULUS: prdata = modulus_q;
				RA_NEGINV:  prdata = neginv_q;
				RA_RSQ:     prdata = rsq_q;
				default:    prdata = '0;
			endcase
		end
	end

	logic [W-1:0] p, ninv, a_in, b_in, y_in;
	assign p    = modulus_q[W-1:0];
	assign ninv = neginv_q[W-1:0];
	assign a_in = operand_a[W-1:0];
	assign b_in = operand_b[W-1:0];
	assign y_in = (opcode == OP_TOM) ? rsq_q[W-1:0] :
		(opcode == OP_FROMM) ? {{(W-1){1'b0}}, 1'b1} : b_in;

	// first cell: t = a*b (from-Montgomery uses a*1)
	logic [2*W-1:0] t_s2;
	side_t          side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [W-1:0]   ninv_s1, ninv_s2;
	logic           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	mma_cell #(.W(W)) u_c1 (.clk(clk), .x(a_in), .y(y_in), .prod_q(t_s2));
	always_ff @(posedge clk) begin
		side_s1 <= {opcode, a_in, b_in, p};
		ninv_s1 <= ninv;
		side_s2 <= side_s1;
		ninv_s2 <= ninv_s1;
	end

	// second cell: m = t_lo * neg_inverse
	logic [2*W-1:0] m_full_s4, t_s3, t_s4;
	mma_cell #(.W(W)) u_c2 (.clk(clk), .x(t_s2[W-1:0]), .y(ninv_s2), .prod_q(m_full_s4));
	always_ff @(posedge clk) begin
		side_s3 <= side_s2; t_s3 <= t_s2;
		side_s4 <= side_s3; t_s4 <= t_s3;
	end

	// third cell: m*p
	logic [2*W-1:0] mp_s6, t_s5, t_s6;
	mma_cell #(.W(W)) u_c3 (.clk(clk), .x(m_full_s4[W-1:0]), .y(side_s4.p), .prod_q(mp_s6));
	always_ff @(posedge clk) begin
		side_s5 <= side_s4; t_s5 <= t_s4;
		side_s6 <= side_s5; t_s6 <= t_s5;
	end

	// registered reduce sum, add and difference
	logic [2*W:0] sum_s7;
	logic [W:0]   asum_s7, diff_s7;
	logic [2:0]   op_s7;
	logic [W-1:0] p_s7;
	always_ff @(posedge clk) begin
		sum_s7  <= {1'b0, t_s6} + {1'b0, mp_s6};
		asum_s7 <= {1'b0, side_s6.a} + {1'b0, side_s6.b};
		diff_s7 <= {1'b0, side_s6.a} - {1'b0, side_s6.b};
		op_s7   <= side_s6.op;
		p_s7    <= side_s6.p;
	end

	// final subtract and select, registered into res_s8
	logic [W:0]   u;
	logic [W-1:0] red, addr_r, subr, res_c;
	always_comb begin
		u      = sum_s7[2*W:W];
		red    = (u >= {1'b0, p_s7}) ? u[W-1:0] - p_s7 : u[W-1:0];
		addr_r = (asum_s7 >= {1'b0, p_s7}) ? asum_s7[W-1:0] - p_s7 : asum_s7[W-1:0];
		subr   = diff_s7[W] ? diff_s7[W-1:0] + p_s7 : diff_s7[W-1:0];
		case (op_s7)
			OP_MMUL, OP_TOM, OP_FROMM: res_c = red;
			OP_ADD: res_c = addr_r;
			OP_SUB: res_c = subr;
			default: res_c = '0;
		endcase
	end
	logic [63:0] res_s8;
	always_ff @(posedge clk) begin
		res_s8 <= 64'(res_c);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end
	assign done   = v_s8;
	assign result = res_s8;

	`MMA_ASSERT(a_lat, clk, arst_n, (start && !busy) |-> ##8 done, "result missing eight cycles after start")
	`MMA_ASSERT(a_nodone, clk, arst_n, !$past(start, 8) |-> !done, "result without item")
	`MMA_ASSERT(a_cfg, clk, arst_n, (wr_en && paddr == 5'd0) |=> modulus_q == $past(pwdata), "modulus write lost")
endmodule

// File: tb/montgomery_modular_alu_test.sv
`timescale 1ns / 1ps
module montgomery_modular_alu_test;
	import mma_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic        done;
	logic [63:0] result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	montgomery_modular_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// shadow copy of the modulus registers
	logic [63:0] cur_mod;
	logic [63:0] cur_ninv;
	logic [63:0] cur_rsq;

	word_t       pending_words[$];
	logic [63:0] expected_results[$];
	int          send_idle_pct;
	int          mismatches;
	int          quiet_cycles;
	bit          cfg_active;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Montgomery reduction of a 128-bit value, carry of the sum kept
	function automatic logic [63:0] redc_expect(input logic [127:0] t);
		logic [63:0]  m;
		logic [128:0] s;
		logic [64:0]  u;
		begin
			m = t[63:0] * cur_ninv;
			s = {1'b0, t} + {1'b0, 128'(m) * 128'(cur_mod)};
			u = s[128:64];
			if (u >= {1'b0, cur_mod})
				u = u - {1'b0, cur_mod};
			return u[63:0];
		end
	endfunction

	function automatic logic [63:0] modular_result(input word_t w);
		logic [64:0] sum;
		begin
			case (w.op)
			OP_MMUL: return redc_expect(128'(w.a) * 128'(w.b));
			OP_ADD: begin
				sum = {1'b0, w.a} + {1'b0, w.b};
				if (sum >= {1'b0, cur_mod})
					sum = sum - {1'b0, cur_mod};
				return sum[63:0];
			end
			OP_SUB: return (w.a >= w.b) ? w.a - w.b : w.a + cur_mod - w.b;
			OP_TOM: return redc_expect(128'(w.a) * 128'(cur_rsq));
			OP_FROMM: return redc_expect({64'd0, w.a});
			default: return 64'd0;
			endcase
		end
	endfunction

	// driver: present the next word, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(modular_result({opcode, operand_a, operand_b}));
			end
			if (!(start && busy)) begin
				if (pending_words.size() > 0 && !cfg_active &&
						$urandom_range(99) >= send_idle_pct) begin
					word_t w;
					w = pending_words.pop_front();
					start     <= 1'b1;
					opcode    <= w.op;
					operand_a <= w.a;
					operand_b <= w.b;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				logic [63:0] exp_val;
				exp_val = expected_results.pop_front();
				if (result !== exp_val) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %h got %h", exp_val, result);
				end
			end
		end
	end

	// watchdog on cycles without any accepted word, result or config access
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_addr_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 3;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
		RA_MODULUS: cur_mod = value;
		RA_NEGINV:  cur_ninv = value;
		default:    cur_rsq = value;
		endcase
	endtask

	// -p^-1 mod 2^64 by Newton iteration
	function automatic logic [63:0] neg_inv_of(input logic [63:0] p);
		logic [63:0] x;
		begin
			x = p;
			for (int i = 0; i < 6; i++)
				x = x * (64'd2 - p * x);
			return -x;
		end
	endfunction

	task automatic set_modulus(input logic [63:0] p, input bit bad_inv);
		logic [128:0] rsq;
		begin
			rsq = (129'd1 << 128) % 129'(p);
			cfg_active = 1'b1;
			@(posedge clk);
			write_reg(RA_MODULUS, p);
			write_reg(RA_NEGINV, bad_inv ? {$urandom, $urandom} : neg_inv_of(p));
			write_reg(RA_RSQ, rsq[63:0]);
			cfg_active = 1'b0;
		end
	endtask

	function automatic logic [63:0] rand_below(input logic [63:0] p);
		return {$urandom, $urandom} % p;
	endfunction

	function automatic logic [63:0] rand_edge(input logic [63:0] p);
		case ($urandom_range(5))
		0: return 64'd0;
		1: return p - 64'd1;
		2: return 64'(p >> 1);
		3: return {$urandom, $urandom};
		default: return rand_below(p);
		endcase
	endfunction

	task automatic queue_random(input int count, input logic [63:0] p);
		word_t w;
		for (int i = 0; i < count; i++) begin
			w.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) :
				3'($urandom_range(4));
			w.a = rand_edge(p);
			w.b = rand_edge(p);
			pending_words.push_back(w);
		end
	endtask

	initial begin
		logic [63:0] moduli[6];
		word_t w;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = '0;
		operand_a = '0;
		operand_b = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_active = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 22;
		cur_mod = 64'd3;
		cur_ninv = 64'h5555555555555555;
		cur_rsq = 64'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset modulus, every opcode incl. unused ones
		for (int op = 0; op < 8; op++) begin
			w.op = 3'(op);
			w.a = 64'd2;
			w.b = 64'd1;
			pending_words.push_back(w);
			w.a = 64'd0;
			w.b = 64'd2;
			pending_words.push_back(w);
		end
		wait_drained();

		// largest odd modulus: carry of the add and of the reduce sum
		set_modulus(64'hFFFFFFFFFFFFFFFF, 1'b0);
		for (int op = 0; op < 5; op++) begin
			w.op = 3'(op);
			w.a = 64'hFFFFFFFFFFFFFFFE;
			w.b = 64'hFFFFFFFFFFFFFFFE;
			pending_words.push_back(w);
		end
		w.op = OP_SUB;
		w.a = 64'd0;
		w.b = 64'hFFFFFFFFFFFFFFFF;
		pending_words.push_back(w);
		w.op = OP_ADD;
		w.a = 64'hFFFFFFFFFFFFFFFF;
		pending_words.push_back(w);
		wait_drained();

		// random phases over several moduli, bad ones among them
		moduli[0] = 64'd1;
		moduli[1] = 64'hFFFFFFFFFFFFFFC5;
		moduli[2] = {$urandom, $urandom} | 64'd1;
		moduli[3] = 64'h8000000000000001;
		moduli[4] = 64'd1000000007;
		moduli[5] = {$urandom, $urandom} & ~64'd1;
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 56 : 0;
			set_modulus(moduli[ph] == 0 ? 64'd2 : moduli[ph], ph == 5);
			queue_random(110, moduli[ph] == 0 ? 64'd2 : moduli[ph]);
			wait_drained();
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: montgomery_modular_alu.f
+incdir+design
design/mma_pkg.sv
design/mma_cell.sv
design/montgomery_modular_alu.sv
tb/montgomery_modular_alu_test.sv
